### sv/tcldp_pkg.sv
// ----------------------------------------------------------------------------
// tcldp_pkg: shared types and constants of the two-channel LED dimmer path
// Field widths, register indexes and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcldp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEVEL_W    = 14;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned RAMP_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0]  BYTE_MAX    = 8'hFF;
  localparam logic               MODE_RESET  = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_LIMIT_ONE = 2'd1,
    CFG_LIMIT_TWO = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] one;
    logic [LEVEL_W-1:0] two;
  } level_pair_t;

  typedef struct packed {
    logic              valid;
    logic [RAMP_W-1:0] level;
    logic              changed;
  } ramp_status_t;

endpackage

`default_nettype wire

### sv/tcldp_if.sv
// ----------------------------------------------------------------------------
// tcldp_if: valid/ready channels of the two-channel LED dimmer path
// Control byte pairs in, filtered drive and enable ramp results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcldp_in_if import tcldp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] brightness;
  logic [BYTE_W-1:0] colour_temp;

  modport source (output valid, output brightness, output colour_temp, input ready);
  modport sink (input valid, input brightness, input colour_temp, output ready);
endinterface

interface tcldp_out_if import tcldp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] drive_one;
  logic               drive_one_valid;
  logic [LEVEL_W-1:0] drive_two;
  logic               drive_two_valid;
  logic [RAMP_W-1:0]  enable_one;
  logic               enable_one_changed;
  logic [RAMP_W-1:0]  enable_two;
  logic               enable_two_changed;

  modport source (
    output valid, input ready,
    output drive_one, output drive_one_valid, output drive_two, output drive_two_valid,
    output enable_one, output enable_one_changed, output enable_two,
    output enable_two_changed
  );
  modport sink (
    input valid, output ready,
    input drive_one, input drive_one_valid, input drive_two, input drive_two_valid,
    input enable_one, input enable_one_changed, input enable_two,
    input enable_two_changed
  );
endinterface

`default_nettype wire

### sv/tcldp_tap_cell.sv
// ----------------------------------------------------------------------------
// tcldp_tap_cell: one tap of the moving-average history line
// Holds one sample of each channel and passes it on when the line shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module tcldp_tap_cell import tcldp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        shift_i,
  input  wire level_pair_t d_i,
  output level_pair_t      q_o
);

  level_pair_t tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= d_i;
    end
  end

  assign q_o = tap_q;

endmodule

`default_nettype wire

### sv/tcldp_ramp.sv
// ----------------------------------------------------------------------------
// tcldp_ramp: per-channel power state machine and enable ramp
// Steps the enable level up or down once per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tcldp_ramp import tcldp_pkg::*; #(
  parameter int unsigned RAMP_STEP = 10,
  parameter int unsigned RAMP_TOP  = 1000
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire logic  active_i,
  output ramp_status_t status_o
);

  typedef enum logic [3:0] {
    PS_DOWN       = 4'b0001,
    PS_PWR_UP     = 4'b0010,
    PS_UP         = 4'b0100,
    PS_PWR_DOWN   = 4'b1000
  } power_state_e;

  localparam logic [RAMP_W:0] StepL   = (RAMP_W+1)'(RAMP_STEP);
  localparam logic [RAMP_W:0] TopL    = (RAMP_W+1)'(RAMP_TOP);
  localparam logic [RAMP_W:0] RampMax = {1'b0, {RAMP_W{1'b1}}};

  power_state_e      state_q, state_d, state_mid;
  logic [RAMP_W-1:0] level_q, level_d;
  logic [RAMP_W:0]   level_ext, level_inc;
  logic              changed;

  assign level_ext = {1'b0, level_q};
  assign level_inc = level_ext + StepL;

  always_comb begin
    state_mid = state_q;
    if (!active_i && state_q == PS_UP) begin
      state_mid = PS_PWR_DOWN;
    end
    if (active_i && state_q == PS_DOWN) begin
      state_mid = PS_PWR_UP;
    end

    state_d = state_mid;
    level_d = level_q;
    changed = 1'b0;
    unique case (state_mid)
      PS_PWR_UP: begin
        if (level_ext <= TopL) begin
          level_d = (level_inc > RampMax) ? RampMax[RAMP_W-1:0] : level_inc[RAMP_W-1:0];
          changed = 1'b1;
        end else begin
          state_d = PS_UP;
        end
      end
      PS_PWR_DOWN: begin
        if (level_q != '0) begin
          level_d = (level_ext > StepL) ? RAMP_W'(level_ext - StepL) : '0;
          changed = 1'b1;
        end else begin
          state_d = PS_DOWN;
        end
      end
      PS_DOWN, PS_UP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_DOWN;
      level_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end

  // The drive is flagged from the state before this transaction moves it.
  assign status_o.valid   = (state_q != PS_PWR_DOWN);
  assign status_o.level   = level_d;
  assign status_o.changed = changed;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("ramp power state lost its one-hot code");

  a_down_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && state_d == PS_DOWN |=> level_q == '0)
    else $error("channel went down with a nonzero enable level");

  a_up_above_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && state_q == PS_PWR_UP && state_d == PS_UP |-> level_ext > TopL)
    else $error("ramp reached up below its top level");
`endif

endmodule

`default_nettype wire

### sv/two_channel_led_dimmer_path.sv
// ----------------------------------------------------------------------------
// two_channel_led_dimmer_path: two-channel LED drive level path
// Mixes, current-limits and averages the drive of two LED channels and ramps
// their enables.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_if carries a brightness and a colour
// temperature byte; each one yields exactly one transaction on out_if with the
// filtered drive of both channels, their valid flags and the enable ramp
// levels. Configuration writes on cfg_we_i / cfg_idx_i / cfg_data_i take effect
// at once; they must be made only while the block is idle (not enforced).
// Timing: the block works on one transaction at a time. A transaction passes
// through the mix multipliers at acceptance, then the limit multipliers, then
// the history line and running sums, then the finish step; a new input is
// taken only once the finish step has handed its result to the output
// register. When FILTER_TAPS is not a power of two, the average is a reciprocal
// multiply, registered in the finish step before the result goes out.
// Reset clears the history line, the sums, the power state machines and the
// ramp levels, and loads the registers with mode 1 and both limits at 255.
// The result sits in an output register; while the receiver stalls, the next
// transaction is still accepted and processed up to the finish step, where it
// waits for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_channel_led_dimmer_path import tcldp_pkg::*; #(
  parameter int unsigned FILTER_TAPS = 32,
  parameter int unsigned RAMP_STEP   = 10,
  parameter int unsigned RAMP_TOP    = 1000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  tcldp_in_if.sink                   in_if,
  tcldp_out_if.source                out_if
);

  localparam int unsigned TapIdxW = $clog2(FILTER_TAPS);
  localparam int unsigned SumW    = LEVEL_W + TapIdxW;
  localparam int unsigned ProdW   = LEVEL_W + LIMIT_W;
  localparam int unsigned MixW    = 2 * BYTE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LIMIT = 4'b0010,
    ST_SUM   = 4'b0100,
    ST_FIN   = 4'b1000
  } dimmer_state_e;

  dimmer_state_e state_q, state_d;

  // Configuration registers.
  logic               mode_q;
  logic [LIMIT_W-1:0] limit_one_q, limit_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      limit_one_q <= LIMIT_RESET;
      limit_two_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MODE:      mode_q      <= cfg_data_i[0];
        CFG_LIMIT_ONE: limit_one_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_LIMIT_TWO: limit_two_q <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshakes.
  logic in_accept, slot_free, div_done, fin_go;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign slot_free   = !out_if.valid || out_if.ready;
  assign fin_go      = (state_q == ST_FIN) && div_done && slot_free;

  // Channel mixing, registered at acceptance.
  logic [BYTE_W-1:0] warm;
  logic [MixW-1:0]   mix_warm, mix_cool;
  level_pair_t       level_q, level_d;

  assign warm     = BYTE_MAX - in_if.colour_temp;
  assign mix_warm = {{BYTE_W{1'b0}}, warm} * {{BYTE_W{1'b0}}, in_if.brightness};
  assign mix_cool = {{BYTE_W{1'b0}}, in_if.colour_temp} * {{BYTE_W{1'b0}}, in_if.brightness};

  always_comb begin
    if (mode_q) begin
      level_d.one = mix_warm[MixW-1:2];
      level_d.two = mix_cool[MixW-1:2];
    end else begin
      level_d.one = {in_if.brightness, 6'b0};
      level_d.two = {in_if.brightness, 6'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= level_d;
    end
  end

  // Current limit scaling.
  logic [ProdW-1:0] prod_one, prod_two;
  level_pair_t      sample_q;

  assign prod_one = ProdW'(level_q.one) * ProdW'(limit_one_q);
  assign prod_two = ProdW'(level_q.two) * ProdW'(limit_two_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LIMIT) begin
      sample_q.one <= prod_one[ProdW-1:LIMIT_W];
      sample_q.two <= prod_two[ProdW-1:LIMIT_W];
    end
  end

  // History line: the tail holds the sample that leaves the window.
  logic        shift;
  level_pair_t tap [FILTER_TAPS];

  assign shift = (state_q == ST_SUM);

  for (genvar i = 0; i < FILTER_TAPS; i++) begin : g_tap
    tcldp_tap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     ((i == 0) ? sample_q : tap[(i == 0) ? 0 : i - 1]),
      .q_o     (tap[i])
    );
  end

  logic [SumW-1:0] sum_one_q, sum_one_d, sum_two_q, sum_two_d;

  assign sum_one_d = sum_one_q - SumW'(tap[FILTER_TAPS-1].one) + SumW'(sample_q.one);
  assign sum_two_d = sum_two_q - SumW'(tap[FILTER_TAPS-1].two) + SumW'(sample_q.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_one_q <= '0;
      sum_two_q <= '0;
    end else if (shift) begin
      sum_one_q <= sum_one_d;
      sum_two_q <= sum_two_d;
    end
  end

  // Average: the sum is below FILTER_TAPS * 2^14, so the quotient fits 14 bits.
  logic [LEVEL_W-1:0] filt_one, filt_two;

  if ((FILTER_TAPS & (FILTER_TAPS - 1)) == 0) begin : g_shift
    assign filt_one = sum_one_q[TapIdxW +: LEVEL_W];
    assign filt_two = sum_two_q[TapIdxW +: LEVEL_W];
    assign div_done = 1'b1;
  end else begin : g_divide
    localparam int unsigned RecipW = SumW + 1;
    localparam int unsigned QuotW  = SumW + RecipW;
    localparam int unsigned Shift  = SumW + TapIdxW;
    localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << Shift) + 64'(FILTER_TAPS) - 64'd1) / 64'(FILTER_TAPS));

    logic [QuotW-1:0]   quot_one, quot_two;
    logic [LEVEL_W-1:0] filt_one_q, filt_two_q;
    logic               div_q;

    // The rounded-up reciprocal with this many fraction bits gives the exact
    // truncated quotient for every sum that the window can hold.
    assign quot_one = QuotW'(sum_one_q) * QuotW'(Recip);
    assign quot_two = QuotW'(sum_two_q) * QuotW'(Recip);
    assign div_done = div_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q <= 1'b0;
      end else if (state_q == ST_SUM) begin
        div_q <= 1'b0;
      end else if (state_q == ST_FIN && !div_q) begin
        div_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (state_q == ST_FIN && !div_q) begin
        filt_one_q <= quot_one[Shift +: LEVEL_W];
        filt_two_q <= quot_two[Shift +: LEVEL_W];
      end
    end

    assign filt_one = filt_one_q;
    assign filt_two = filt_two_q;
  end

  // Power state machines and enable ramps.
  ramp_status_t ramp_one, ramp_two;

  tcldp_ramp #(
    .RAMP_STEP (RAMP_STEP),
    .RAMP_TOP  (RAMP_TOP)
  ) u_ramp_one (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fin_go),
    .active_i (filt_one != '0),
    .status_o (ramp_one)
  );

  tcldp_ramp #(
    .RAMP_STEP (RAMP_STEP),
    .RAMP_TOP  (RAMP_TOP)
  ) u_ramp_two (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fin_go),
    .active_i (filt_two != '0),
    .status_o (ramp_two)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_LIMIT;
      ST_LIMIT: state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  logic              out_valid_q;
  logic [LEVEL_W-1:0] drive_one_q, drive_two_q;
  logic              drive_one_valid_q, drive_two_valid_q;
  logic [RAMP_W-1:0] enable_one_q, enable_two_q;
  logic              enable_one_changed_q, enable_two_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      drive_one_q          <= filt_one;
      drive_two_q          <= filt_two;
      drive_one_valid_q    <= ramp_one.valid;
      drive_two_valid_q    <= ramp_two.valid;
      enable_one_q         <= ramp_one.level;
      enable_two_q         <= ramp_two.level;
      enable_one_changed_q <= ramp_one.changed;
      enable_two_changed_q <= ramp_two.changed;
    end
  end

  assign out_if.valid              = out_valid_q;
  assign out_if.drive_one          = drive_one_q;
  assign out_if.drive_one_valid    = drive_one_valid_q;
  assign out_if.drive_two          = drive_two_q;
  assign out_if.drive_two_valid    = drive_two_valid_q;
  assign out_if.enable_one         = enable_one_q;
  assign out_if.enable_one_changed = enable_one_changed_q;
  assign out_if.enable_two         = enable_two_q;
  assign out_if.enable_two_changed = enable_two_changed_q;

`ifndef SYNTHESIS
  a_seq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state lost its one-hot code");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_LIMIT)
    else $error("accepted transaction did not enter the limit step");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result appeared without a finished transaction");

  a_shift_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |=> !shift)
    else $error("history line shifted twice for one transaction");
`endif

endmodule

`default_nettype wire

### tb/tb_two_channel_led_dimmer_path.sv
// ----------------------------------------------------------------------------
// tb_two_channel_led_dimmer_path: self-checking bench for the LED dimmer path
// Drives brightness and colour temperature pairs under several register
// settings, predicts the filtered drive levels and enable ramps of both
// channels, and compares every output transaction against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_channel_led_dimmer_path;
  timeunit 1ns;
  timeprecision 1ps;

  import tcldp_pkg::*;

  localparam int unsigned TAPS           = 32;
  localparam int unsigned STEP           = 10;
  localparam int unsigned TOP            = 1000;
  localparam int unsigned RAMP_LIMIT     = 2047;
  localparam int unsigned LEVEL_MASK     = 16383;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned PHASE_ITEMS    = 320;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    PWR_DOWN    = 2'd0,
    PWR_RISING  = 2'd1,
    PWR_UP      = 2'd2,
    PWR_FALLING = 2'd3
  } pwr_state_e;

  typedef enum int {RUN_LIT, RUN_DARK, RUN_NOISE} run_kind_e;
  typedef enum int {DARK_BOTH, DARK_ONE, DARK_TWO} dark_side_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_one;
    logic               drive_one_valid;
    logic [LEVEL_W-1:0] drive_two;
    logic               drive_two_valid;
    logic [RAMP_W-1:0]  enable_one;
    logic               enable_one_changed;
    logic [RAMP_W-1:0]  enable_two;
    logic               enable_two_changed;
  } drive_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcldp_in_if  ctrl_ch ();
  tcldp_out_if drive_ch ();

  two_channel_led_dimmer_path #(
    .FILTER_TAPS(TAPS),
    .RAMP_STEP  (STEP),
    .RAMP_TOP   (TOP)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (ctrl_ch),
    .out_if    (drive_ch)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the block's registers and state.
  logic        mix_mode;
  int unsigned limit [2];
  int unsigned history [2][TAPS];
  int unsigned run_sum [2];
  int unsigned slot;
  pwr_state_e  pwr [2];
  int unsigned ramp [2];

  drive_result_t expected_drive [$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            gaps_on = 1'b0;
  bit            stalls_on = 1'b0;

  function automatic logic advance_enable_ramp(input int c, input int unsigned avg);
    logic stepped;
    stepped = 1'b0;
    if (avg == 0 && pwr[c] == PWR_UP) pwr[c] = PWR_FALLING;
    if (avg != 0 && pwr[c] == PWR_DOWN) pwr[c] = PWR_RISING;
    if (pwr[c] == PWR_RISING) begin
      if (ramp[c] <= TOP) begin
        ramp[c] = (ramp[c] + STEP > RAMP_LIMIT) ? RAMP_LIMIT : ramp[c] + STEP;
        stepped = 1'b1;
      end else begin
        pwr[c] = PWR_UP;
      end
    end
    if (pwr[c] == PWR_FALLING) begin
      if (ramp[c] > 0) begin
        ramp[c] = (ramp[c] > STEP) ? ramp[c] - STEP : 0;
        stepped = 1'b1;
      end else begin
        pwr[c] = PWR_DOWN;
      end
    end
    return stepped;
  endfunction

  function automatic void predict_drive(input logic [7:0] bright, input logic [7:0] temp);
    int unsigned   bi;
    int unsigned   ti;
    int unsigned   raw [2];
    int unsigned   lvl;
    int unsigned   avg [2];
    logic          live [2];
    logic          stepped [2];
    drive_result_t r;
    bi = 32'(bright);
    ti = 32'(temp);
    if (mix_mode) begin
      raw[0] = ((255 - ti) * bi) >> 2;
      raw[1] = (ti * bi) >> 2;
    end else begin
      raw[0] = bi << 6;
      raw[1] = raw[0];
    end
    for (int c = 0; c < 2; c++) begin
      lvl = ((raw[c] * limit[c]) >> 8) & LEVEL_MASK;
      run_sum[c] = run_sum[c] - history[c][slot] + lvl;
      history[c][slot] = lvl;
      avg[c] = (run_sum[c] / TAPS) & LEVEL_MASK;
      // The valid flag looks at the power state before this item moves it.
      live[c] = (pwr[c] != PWR_FALLING);
      stepped[c] = advance_enable_ramp(c, avg[c]);
    end
    slot = (slot + 1) % TAPS;
    r.drive_one          = LEVEL_W'(avg[0]);
    r.drive_one_valid    = live[0];
    r.drive_two          = LEVEL_W'(avg[1]);
    r.drive_two_valid    = live[1];
    r.enable_one         = RAMP_W'(ramp[0]);
    r.enable_one_changed = stepped[0];
    r.enable_two         = RAMP_W'(ramp[1]);
    r.enable_two_changed = stepped[1];
    expected_drive.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  // Receiver: random stall bursts while stalls are enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      drive_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      drive_ch.ready <= 1'b0;
    end else begin
      drive_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    drive_result_t want;
    if (rst_ni && drive_ch.valid && drive_ch.ready) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output transaction with no prediction pending", $realtime);
      end else begin
        want = expected_drive.pop_front();
        check_field("drive_one", want.drive_one, drive_ch.drive_one);
        check_field("drive_one_valid", want.drive_one_valid, drive_ch.drive_one_valid);
        check_field("drive_two", want.drive_two, drive_ch.drive_two);
        check_field("drive_two_valid", want.drive_two_valid, drive_ch.drive_two_valid);
        check_field("enable_one", want.enable_one, drive_ch.enable_one);
        check_field("enable_one_changed", want.enable_one_changed,
                    drive_ch.enable_one_changed);
        check_field("enable_two", want.enable_two, drive_ch.enable_two);
        check_field("enable_two_changed", want.enable_two_changed,
                    drive_ch.enable_two_changed);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((ctrl_ch.valid && ctrl_ch.ready) || (drive_ch.valid && drive_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:      mix_mode = data[0];
      CFG_LIMIT_ONE: limit[0] = 32'(data);
      CFG_LIMIT_TWO: limit[1] = 32'(data);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sends one control pair and leaves valid high, so that a following
  // transaction can go out back to back.
  task automatic send_pair(input logic [7:0] bright, input logic [7:0] temp);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      ctrl_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ctrl_ch.valid       <= 1'b1;
    ctrl_ch.brightness  <= bright;
    ctrl_ch.colour_temp <= temp;
    @(posedge clk_i);
    while (!ctrl_ch.ready) @(posedge clk_i);
    predict_drive(bright, temp);
  endtask

  task automatic drain();
    ctrl_ch.valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_config();
    send_pair(8'h00, 8'h00);
    send_pair(8'hFF, 8'hFF);
    send_pair(8'hFF, 8'h00);
    send_pair(8'h00, 8'hFF);
    send_pair(8'hAA, 8'h55);
    send_pair(8'h55, 8'hAA);
    send_pair(8'h01, 8'hFE);
    drain();
  endtask

  task automatic test_register_writes();
    // Only bit 0 of the mode register exists; the spare index must not land.
    write_reg(CFG_MODE, 8'hFE);
    write_reg(CFG_SPARE, 8'h01);
    send_pair(8'hFF, 8'h00);
    send_pair(8'h80, 8'h4D);
    send_pair(8'h01, 8'hC8);
    drain();
    write_reg(CFG_LIMIT_ONE, 8'h00);
    write_reg(CFG_LIMIT_TWO, 8'h80);
    send_pair(8'hFF, 8'hFF);
    send_pair(8'hC8, 8'h64);
    drain();
    write_reg(CFG_MODE, 8'h01);
    write_reg(CFG_LIMIT_ONE, 8'hFF);
    write_reg(CFG_LIMIT_TWO, 8'h00);
    send_pair(8'hFF, 8'h00);
    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'hFF);
    drain();
  endtask

  // Runs of lit and dark input, each 20 to 150 items long, broken up by bursts
  // of 5 to 40 items of arbitrary input.
  task automatic run_traffic(input logic mode, input logic [7:0] lim_one,
                             input logic [7:0] lim_two, input int unsigned count,
                             input bit idling);
    run_kind_e   kind;
    dark_side_e  side;
    int unsigned run_len;
    int unsigned sent;
    int unsigned pick;
    bit          paused;
    logic [7:0]  bright;
    logic [7:0]  temp;
    temp = 8'($urandom);
    write_reg(CFG_MODE, {temp[7:1], mode});
    write_reg(CFG_LIMIT_ONE, lim_one);
    write_reg(CFG_LIMIT_TWO, lim_two);
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? RUN_LIT : (pick < 7) ? RUN_DARK : RUN_NOISE;
      run_len = (kind == RUN_NOISE) ? $urandom_range(5, 40) : $urandom_range(20, 150);
      side = dark_side_e'($urandom_range(0, 2));
      gaps_on = idling && $urandom_range(0, 2) != 0;
      stalls_on = idling && $urandom_range(0, 2) != 0;
      for (int i = 0; i < run_len && sent < count; i++) begin
        bright = 8'($urandom);
        temp = 8'($urandom);
        case (kind)
          RUN_LIT: begin
            if (bright == 8'h00) bright = 8'h01;
          end
          RUN_DARK: begin
            case (side)
              DARK_BOTH: bright = 8'h00;
              DARK_ONE:  temp = BYTE_MAX;
              default:   temp = 8'h00;
            endcase
          end
          default: begin
            if ($urandom_range(0, 3) == 0) bright = 8'h00;
          end
        endcase
        send_pair(bright, temp);
        sent++;
        if (!paused && sent >= count / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();
  endtask

  task automatic test_random_traffic();
    run_traffic(1'b1, 8'hFF, 8'hFF, PHASE_ITEMS, 1'b1);
    run_traffic(1'b0, 8'h00, 8'hFF, PHASE_ITEMS, 1'b1);
    run_traffic(1'b1, 8'h01, 8'h80, PHASE_ITEMS, 1'b1);
    run_traffic(1'b0, 8'hFF, 8'h01, PHASE_ITEMS, 1'b1);
    run_traffic(1'b1, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                PHASE_ITEMS, 1'b1);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_traffic(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), PHASE_ITEMS, 1'b0);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_MODE;
    cfg_data            <= 8'h00;
    ctrl_ch.valid       <= 1'b0;
    ctrl_ch.brightness  <= 8'h00;
    ctrl_ch.colour_temp <= 8'h00;
    mix_mode = MODE_RESET;
    limit[0] = 32'(LIMIT_RESET);
    limit[1] = 32'(LIMIT_RESET);
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < TAPS; k++) history[c][k] = 0;
      run_sum[c] = 0;
      pwr[c] = PWR_DOWN;
      ramp[c] = 0;
    end
    slot = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_register_writes();
    test_random_traffic();
    test_back_to_back();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
